// File: rtl/core/rctc_pkg.sv
// Shared types and constants for the reference-counted tag cache table.
package rctc_pkg;

    localparam int unsigned TAG_W  = 16;
    localparam int unsigned REFS_W = 8;
    localparam int unsigned SLOT_W = 5;

    localparam logic [REFS_W-1:0] REFS_MAX = '1;

    typedef enum logic [1:0] {
        CMD_ACQUIRE = 2'd0,
        CMD_DUP     = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_LOCK    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_OVER  = 2'd2,
        ST_UNDER = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_READ,
        FSM_MODIFY
    } fsm_t;

    // one table entry as stored in the slot memory
    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic              used;
        logic [REFS_W-1:0] refs;
        logic              valid;
    } entry_t;

    // request context handed to the update logic
    typedef struct packed {
        cmd_t             cmd;
        logic             found;
        logic             have_free;
        logic             in_range;
        logic             no_links;
        logic [TAG_W-1:0] num;
    } op_t;

    // response fields, slot number excluded
    typedef struct packed {
        status_t           status;
        logic              was_hit;
        logic [REFS_W-1:0] count;
        logic              destroy;
        logic              need_load;
    } resp_t;

endpackage

// File: rtl/core/rctc_slot_mem.sv
// Slot memory: registered synchronous read, one write port, per-entry written flags.
module rctc_slot_mem
    import rctc_pkg::*;
#(
    parameter int unsigned SLOTS = 32,
    parameter int unsigned AW    = 5
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_entry,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_entry
);

    entry_t             mem [SLOTS];
    logic [SLOTS-1:0]   written_reg;
    entry_t             rd_data_reg;
    logic               rd_written_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_entry;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // never-written entries read back as free (unused, count zero, invalid)
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                written_reg[wr_addr] <= 1'b1;
            end
            rd_written_reg <= written_reg[rd_addr];
        end
    end

    always_comb begin
        rd_entry     = rd_data_reg;
        if (!rd_written_reg) begin
            rd_entry.used  = 1'b0;
            rd_entry.refs  = '0;
            rd_entry.valid = 1'b0;
        end
    end

endmodule

// File: rtl/core/rctc_update.sv
// Read-modify-write logic: new entry contents and response for one request.
module rctc_update
    import rctc_pkg::*;
(
    input  op_t    op,
    input  entry_t entry,
    output entry_t new_entry,
    output logic   wr_en,
    output resp_t  resp
);

    logic [REFS_W-1:0] refs_inc;
    logic [REFS_W-1:0] refs_dec;

    assign refs_inc = entry.refs + REFS_W'(1);
    assign refs_dec = entry.refs - REFS_W'(1);

    always_comb begin
        new_entry = entry;
        wr_en     = 1'b0;
        resp      = '{status: ST_OK, was_hit: 1'b0, count: '0,
                      destroy: 1'b0, need_load: 1'b0};
        case (op.cmd)
            CMD_ACQUIRE: begin
                if (op.found) begin
                    resp.was_hit = 1'b1;
                    if (entry.refs == REFS_MAX) begin
                        resp.status = ST_OVER;
                        resp.count  = entry.refs;
                    end else begin
                        new_entry.refs = refs_inc;
                        wr_en          = 1'b1;
                        resp.count     = refs_inc;
                    end
                end else if (op.have_free) begin
                    new_entry = '{tag: op.num, used: 1'b1, refs: REFS_W'(1), valid: 1'b0};
                    wr_en      = 1'b1;
                    resp.count = REFS_W'(1);
                end else begin
                    resp.status = ST_FULL;
                end
            end
            CMD_DUP: begin
                if (op.in_range) begin
                    resp.count = entry.refs;
                    if (entry.refs == REFS_MAX) begin
                        resp.status = ST_OVER;
                    end else begin
                        new_entry.refs = refs_inc;
                        wr_en          = 1'b1;
                        resp.count     = refs_inc;
                    end
                end
            end
            CMD_RELEASE: begin
                if (op.in_range) begin
                    if (entry.refs == '0) begin
                        resp.status = ST_UNDER;
                    end else begin
                        new_entry.refs = refs_dec;
                        wr_en          = 1'b1;
                        resp.count     = refs_dec;
                        // last reference gone and no links: free the slot
                        if (refs_dec == '0 && op.no_links) begin
                            new_entry.used  = 1'b0;
                            new_entry.valid = 1'b0;
                            resp.destroy    = 1'b1;
                        end
                    end
                end
            end
            CMD_LOCK: begin
                if (op.in_range) begin
                    resp.need_load  = ~entry.valid;
                    resp.count      = entry.refs;
                    new_entry.valid = 1'b1;
                    wr_en           = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// File: rtl/core/refcounted_tag_cache_table_top.sv
// Top level of the reference-counted tag cache table: control FSM and slot scan.
//
// Usage:
//   Request channel (s_*): command, object number, slot index, no-links flag.
//   Result channel (m_*): one result per request, in request order.
//   Acquire walks every slot through the memory read port, one slot a
//   cycle, looking for the first tag match and the first zero-count slot,
//   then reads the chosen slot and writes it back.
//   Dup, release and lock read the addressed slot and write it back.
//   One request is in work at a time; s_ready is high while the block is
//   idle, also while an earlier result still sits in the output register.
//   The single slot memory read port sets the pace: one slot read per cycle.
//   If the receiver stalls, the finished request waits in the modify step
//   and the memory is not written until the output register is free.
//   Reset: synchronous, active low. All slots read as free (unused, count
//   zero, contents invalid) right after reset; no clearing pass is needed.
//   A slot index at or beyond SLOTS is ignored and echoed with count zero.
module refcounted_tag_cache_table_top
    import rctc_pkg::*;
#(
    parameter int unsigned SLOTS = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_command,
    input  logic [TAG_W-1:0]  s_object_number,
    input  logic [SLOT_W-1:0] s_slot_index,
    input  logic              s_no_links_left,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [SLOT_W-1:0] m_result_slot,
    output logic [1:0]        m_status,
    output logic              m_was_hit,
    output logic [REFS_W-1:0] m_count_after,
    output logic              m_destroy,
    output logic              m_need_load
);

    localparam int unsigned AW = $clog2(SLOTS);     // slot address width
    localparam int unsigned CW = $clog2(SLOTS + 1); // scan counter, holds SLOTS
    localparam int unsigned IW = (AW > SLOT_W) ? AW : SLOT_W;

    // control state
    fsm_t              state_reg,  state_next;
    logic              pend_reg,   pend_next;   // scan read data valid this cycle
    logic              m_valid_reg, m_valid_next;

    // request context
    cmd_t              cmd_reg,     cmd_next;
    logic [TAG_W-1:0]  num_reg,     num_next;
    logic [SLOT_W-1:0] idx_reg,     idx_next;
    logic              nolinks_reg, nolinks_next;
    logic              inrng_reg,   inrng_next;

    // scan bookkeeping
    logic [CW-1:0]     scan_cnt_reg, scan_cnt_next;
    logic [AW-1:0]     pend_addr_reg, pend_addr_next;
    logic              found_reg,   found_next;
    logic              free_reg,    free_next;
    logic [AW-1:0]     hit_at_reg,  hit_at_next;
    logic [AW-1:0]     free_at_reg, free_at_next;
    logic [AW-1:0]     addr_reg,    addr_next;

    // result register
    logic [SLOT_W-1:0] rslot_reg,   rslot_next;
    resp_t             resp_reg,    resp_next;

    // memory and update wiring
    logic [AW-1:0]     rd_addr;
    entry_t            rd_entry;
    logic              mem_wr;
    entry_t            new_entry;
    logic              upd_wr;
    resp_t             upd_resp;
    op_t               op;

    logic [IW-1:0]     s_idx_wide;
    logic [AW-1:0]     acq_addr;
    logic              out_free;
    logic              tag_match;

    assign s_idx_wide = IW'(s_slot_index);
    assign acq_addr   = found_reg ? hit_at_reg : free_at_reg;
    assign out_free   = !m_valid_reg || m_ready;
    assign tag_match  = rd_entry.used && (rd_entry.tag == num_reg);

    assign op = '{cmd: cmd_reg, found: found_reg, have_free: free_reg,
                  in_range: inrng_reg, no_links: nolinks_reg, num: num_reg};

    rctc_slot_mem #(
        .SLOTS (SLOTS),
        .AW    (AW)
    ) u_slot_mem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry),
        .wr_en    (mem_wr),
        .wr_addr  (addr_reg),
        .wr_entry (new_entry)
    );

    rctc_update u_update (
        .op        (op),
        .entry     (rd_entry),
        .new_entry (new_entry),
        .wr_en     (upd_wr),
        .resp      (upd_resp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= FSM_IDLE;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        num_reg       <= num_next;
        idx_reg       <= idx_next;
        nolinks_reg   <= nolinks_next;
        inrng_reg     <= inrng_next;
        scan_cnt_reg  <= scan_cnt_next;
        pend_addr_reg <= pend_addr_next;
        found_reg     <= found_next;
        free_reg      <= free_next;
        hit_at_reg    <= hit_at_next;
        free_at_reg   <= free_at_next;
        addr_reg      <= addr_next;
        rslot_reg     <= rslot_next;
        resp_reg      <= resp_next;
    end

    always_comb begin
        state_next     = state_reg;
        pend_next      = 1'b0;
        m_valid_next   = m_valid_reg && !m_ready;
        cmd_next       = cmd_reg;
        num_next       = num_reg;
        idx_next       = idx_reg;
        nolinks_next   = nolinks_reg;
        inrng_next     = inrng_reg;
        scan_cnt_next  = scan_cnt_reg;
        pend_addr_next = pend_addr_reg;
        found_next     = found_reg;
        free_next      = free_reg;
        hit_at_next    = hit_at_reg;
        free_at_next   = free_at_reg;
        addr_next      = addr_reg;
        rslot_next     = rslot_reg;
        resp_next      = resp_reg;
        rd_addr        = addr_reg;
        mem_wr         = 1'b0;
        s_ready        = 1'b0;

        case (state_reg)
            FSM_IDLE: begin
                s_ready = 1'b1;
                // direct commands read their slot right at acceptance
                rd_addr = s_idx_wide[AW-1:0];
                if (s_valid) begin
                    cmd_next      = cmd_t'(s_command);
                    num_next      = s_object_number;
                    idx_next      = s_slot_index;
                    nolinks_next  = s_no_links_left;
                    inrng_next    = 32'(s_slot_index) < SLOTS;
                    addr_next     = s_idx_wide[AW-1:0];
                    scan_cnt_next = '0;
                    found_next    = 1'b0;
                    free_next     = 1'b0;
                    hit_at_next   = '0;
                    free_at_next  = '0;
                    state_next    = (cmd_t'(s_command) == CMD_ACQUIRE) ?
                                    FSM_SCAN : FSM_MODIFY;
                end
            end
            FSM_SCAN: begin
                rd_addr = scan_cnt_reg[AW-1:0];
                if (scan_cnt_reg < CW'(SLOTS)) begin
                    pend_next      = 1'b1;
                    pend_addr_next = scan_cnt_reg[AW-1:0];
                    scan_cnt_next  = scan_cnt_reg + CW'(1);
                end else begin
                    state_next = FSM_READ;
                end
                // first tag match and first zero-count slot, in slot order
                if (pend_reg) begin
                    if (!found_reg && tag_match) begin
                        found_next  = 1'b1;
                        hit_at_next = pend_addr_reg;
                    end
                    if (!free_reg && rd_entry.refs == '0) begin
                        free_next    = 1'b1;
                        free_at_next = pend_addr_reg;
                    end
                end
            end
            FSM_READ: begin
                rd_addr    = acq_addr;
                addr_next  = acq_addr;
                state_next = FSM_MODIFY;
            end
            FSM_MODIFY: begin
                // re-read the same slot while stalled so the data stays current
                rd_addr = addr_reg;
                if (out_free) begin
                    mem_wr       = upd_wr;
                    resp_next    = upd_resp;
                    m_valid_next = 1'b1;
                    state_next   = FSM_IDLE;
                    if (cmd_reg == CMD_ACQUIRE) begin
                        rslot_next = (found_reg || free_reg) ? SLOT_W'(addr_reg) : '0;
                    end else begin
                        rslot_next = idx_reg;
                    end
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    assign m_valid       = m_valid_reg;
    assign m_result_slot = rslot_reg;
    assign m_status      = resp_reg.status;
    assign m_was_hit     = resp_reg.was_hit;
    assign m_count_after = resp_reg.count;
    assign m_destroy     = resp_reg.destroy;
    assign m_need_load   = resp_reg.need_load;

endmodule

// File: rtl/core/rctc_check.sv
// Port-level assertions for the cache table, bound to the top level.
module rctc_check
    import rctc_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [SLOT_W-1:0] m_result_slot,
    input logic [1:0]        m_status,
    input logic              m_was_hit,
    input logic [REFS_W-1:0] m_count_after,
    input logic              m_destroy,
    input logic              m_need_load
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_slot) && $stable(m_status)
            && $stable(m_count_after) && $stable(m_destroy) && $stable(m_need_load))
        else $error("result changed while stalled");

    // one request in work at a time
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while busy");

    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_FULL |->
            m_result_slot == '0 && m_count_after == '0 && !m_was_hit)
        else $error("bad full response");

    a_destroy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_destroy |-> m_count_after == '0 && m_status == ST_OK
            && !m_was_hit && !m_need_load)
        else $error("bad destroy response");

    a_over: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_OVER |-> m_count_after == REFS_MAX)
        else $error("overflow with count below max");

endmodule

bind refcounted_tag_cache_table_top rctc_check u_rctc_check (.*);
